// File: hw/rtl/lcdt_pkg.sv
// ----------------------------------------------------------------------------
// LCD scan-line mode timer package
// Shared widths, mode and register codes, and the structs that travel
// between the configuration registers, the step logic and the top level.
// ----------------------------------------------------------------------------
package lcdt_pkg;

  // Field and counter widths.
  localparam int unsigned CYC_W  = 12;
  localparam int unsigned CNT_W  = 20;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned CTE_W  = 11;
  localparam int unsigned DUR_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Mode durations in single speed, in machine cycles.
  localparam int unsigned LINE_CYCLES  = 456;
  localparam int unsigned OAM_CYCLES   = 80;
  localparam int unsigned XFER_CYCLES  = 172;
  localparam int unsigned HBL_CYCLES   = 204;
  localparam int unsigned FRAME_CYCLES = 70224;

  // Line numbers of interest.
  localparam logic [LINE_W-1:0] LINE_VBLANK_START = 8'd144;
  localparam logic [LINE_W-1:0] LINE_WRAP         = 8'd153;

  // Largest value shown on the countdown output.
  localparam logic [CTE_W-1:0] CTE_MAX = '1;

  // STAT interrupt enable bit positions.
  localparam int unsigned STAT_EN_HBLANK  = 0;
  localparam int unsigned STAT_EN_VBLANK  = 1;
  localparam int unsigned STAT_EN_OAM     = 2;
  localparam int unsigned STAT_EN_COMPARE = 3;

  // Display mode codes as seen on the lcd_mode output.
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LCD_ON       = 2'd0,
    CFG_STAT_EN      = 2'd1,
    CFG_LINE_COMPARE = 2'd2,
    CFG_DOUBLE_SPEED = 2'd3
  } cfg_idx_e;

  // Configuration register contents.
  typedef struct packed {
    logic              lcd_on;
    logic [3:0]        stat_int_enables;
    logic [LINE_W-1:0] line_compare;
    logic              double_speed;
  } cfg_t;

  // Timer state carried from one beat to the next.
  typedef struct packed {
    logic signed [CNT_W-1:0] line_cd;
    logic signed [CNT_W-1:0] frame_cd;
    logic [LINE_W-1:0]       line;
    mode_e                   mode;
    logic                    coin;
  } state_t;

  // One result beat.
  typedef struct packed {
    logic [LINE_W-1:0] current_line;
    mode_e             lcd_mode;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              frame_done;
    logic              draw_line;
    logic              hblank_start;
    logic [CTE_W-1:0]  cycles_to_event;
  } result_t;

endpackage

// File: hw/rtl/lcdt_cfg_regs.sv
// ----------------------------------------------------------------------------
// LCD timer configuration registers
// Holds the four configuration registers; writes are taken every cycle.
// ----------------------------------------------------------------------------
module lcdt_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  lcdt_pkg::cfg_idx_e                  cfg_index_i,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output lcdt_pkg::cfg_t                      cfg_o
);

  lcdt_pkg::cfg_t cfg_q, cfg_d;

  // The register file never holds off a write.
  assign cfg_ready_o = 1'b1;

  // Decode the index and update the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lcdt_pkg::CFG_LCD_ON:       cfg_d.lcd_on           = cfg_data_i[0];
        lcdt_pkg::CFG_STAT_EN:      cfg_d.stat_int_enables = cfg_data_i[3:0];
        lcdt_pkg::CFG_LINE_COMPARE: cfg_d.line_compare     = cfg_data_i;
        lcdt_pkg::CFG_DOUBLE_SPEED: cfg_d.double_speed     = cfg_data_i[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lcd_on           <= 1'b1;
      cfg_q.stat_int_enables <= '0;
      cfg_q.line_compare     <= '0;
      cfg_q.double_speed     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/lcdt_step.sv
// ----------------------------------------------------------------------------
// LCD timer step logic
// Combinational next state and result for one beat of elapsed cycles:
// one saturating subtract, at most one mode transition, one saturating add.
// ----------------------------------------------------------------------------
module lcdt_step #(
  parameter int unsigned FRAME_CYCLES = lcdt_pkg::FRAME_CYCLES
) (
  input  lcdt_pkg::cfg_t                 cfg_i,
  input  lcdt_pkg::state_t               state_i,
  input  logic [lcdt_pkg::CYC_W-1:0]     cyc_i,
  output lcdt_pkg::state_t               state_o,
  output lcdt_pkg::result_t              result_o
);

  localparam int unsigned EXT_W = lcdt_pkg::CNT_W + 2;
  localparam logic signed [lcdt_pkg::CNT_W-1:0] FRAME_BASE =
    lcdt_pkg::CNT_W'(FRAME_CYCLES);

  // Clamp a widened value back into the signed counter range.
  function automatic logic signed [lcdt_pkg::CNT_W-1:0] sat_cnt(
    input logic signed [EXT_W-1:0] v
  );
    logic ovf;
    logic signed [lcdt_pkg::CNT_W-1:0] r;
    ovf = (v[EXT_W-1:lcdt_pkg::CNT_W-1] != '0) && (v[EXT_W-1:lcdt_pkg::CNT_W-1] != '1);
    if (!ovf) begin
      r = v[lcdt_pkg::CNT_W-1:0];
    end else if (v[EXT_W-1]) begin
      r = {1'b1, {(lcdt_pkg::CNT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(lcdt_pkg::CNT_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Scale a mode duration for double speed.
  function automatic logic [lcdt_pkg::DUR_W-1:0] dur(input int unsigned base, input logic dbl);
    logic [lcdt_pkg::DUR_W-1:0] b;
    b = lcdt_pkg::DUR_W'(base);
    return dbl ? (b << 1) : b;
  endfunction

  // Main step.
  always_comb begin
    logic signed [EXT_W-1:0]         sub_ext;
    logic signed [lcdt_pkg::CNT_W-1:0] sub_sat;
    logic signed [EXT_W-1:0]         frame_add;
    logic [lcdt_pkg::DUR_W-1:0]      add;
    logic [lcdt_pkg::LINE_W-1:0]     line_inc;
    logic                            dbl;
    lcdt_pkg::result_t               res;
    lcdt_pkg::state_t                nxt;

    dbl       = cfg_i.double_speed;
    nxt       = state_i;
    res       = '0;
    add       = '0;
    line_inc  = state_i.line + 1'b1;
    frame_add = dbl ? (EXT_W'(FRAME_BASE) <<< 1) : EXT_W'(FRAME_BASE);
    sub_ext   = '0;
    sub_sat   = '0;

    if (!cfg_i.lcd_on) begin
      // Display off: reset line to zero and mode to horizontal blank, run the frame countdown.
      nxt.line_cd = lcdt_pkg::CNT_W'(dur(lcdt_pkg::LINE_CYCLES, dbl));
      nxt.line    = '0;
      nxt.mode    = lcdt_pkg::MODE_HBLANK;
      nxt.coin    = 1'b0;
      sub_ext     = EXT_W'(state_i.frame_cd) - EXT_W'(cyc_i);
      sub_sat     = sat_cnt(sub_ext);
      nxt.frame_cd = sub_sat;
      if (sub_sat[lcdt_pkg::CNT_W-1] || (sub_sat == '0)) begin
        nxt.frame_cd   = sat_cnt(EXT_W'(sub_sat) + frame_add);
        res.frame_done = 1'b1;
      end
    end else begin
      sub_ext     = EXT_W'(state_i.line_cd) - EXT_W'(cyc_i);
      sub_sat     = sat_cnt(sub_ext);
      nxt.line_cd = sub_sat;
      if (sub_sat[lcdt_pkg::CNT_W-1] || (sub_sat == '0)) begin
        if (state_i.mode == lcdt_pkg::MODE_OAM) begin
          // OAM scan done: start pixel transfer.
          nxt.mode      = lcdt_pkg::MODE_XFER;
          add           = dur(lcdt_pkg::XFER_CYCLES, dbl);
          res.draw_line = 1'b1;
        end else if (state_i.mode == lcdt_pkg::MODE_XFER) begin
          // Transfer done: horizontal blank.
          nxt.mode         = lcdt_pkg::MODE_HBLANK;
          res.stat_irq     = cfg_i.stat_int_enables[lcdt_pkg::STAT_EN_HBLANK];
          add              = dur(lcdt_pkg::HBL_CYCLES, dbl);
          res.hblank_start = 1'b1;
        end else if ((state_i.line == '0) && (state_i.mode == lcdt_pkg::MODE_VBLANK)) begin
          // Leaving the wrapped line zero: first OAM scan of the frame.
          nxt.mode = lcdt_pkg::MODE_OAM;
          add      = dur(lcdt_pkg::OAM_CYCLES, dbl);
        end else begin
          // Line change.
          nxt.line = line_inc;
          if ((line_inc < lcdt_pkg::LINE_VBLANK_START) || (line_inc >= lcdt_pkg::LINE_WRAP)) begin
            res.stat_irq = cfg_i.stat_int_enables[lcdt_pkg::STAT_EN_OAM];
            if (line_inc >= lcdt_pkg::LINE_WRAP) begin
              nxt.line = '0;
              add      = dur(lcdt_pkg::LINE_CYCLES, dbl);
            end else begin
              nxt.mode = lcdt_pkg::MODE_OAM;
              add      = dur(lcdt_pkg::OAM_CYCLES, dbl);
            end
          end else begin
            // Vertical blank lines take a whole line each.
            add = dur(lcdt_pkg::LINE_CYCLES, dbl);
            if (line_inc == lcdt_pkg::LINE_VBLANK_START) begin
              nxt.mode       = lcdt_pkg::MODE_VBLANK;
              res.vblank_irq = 1'b1;
              res.frame_done = 1'b1;
              if (cfg_i.stat_int_enables[lcdt_pkg::STAT_EN_VBLANK]) begin
                res.stat_irq = 1'b1;
              end
            end
          end
          // Line compare is refreshed on every line change.
          nxt.coin = (nxt.line == cfg_i.line_compare);
          if (nxt.coin && cfg_i.stat_int_enables[lcdt_pkg::STAT_EN_COMPARE]) begin
            res.stat_irq = 1'b1;
          end
        end
        nxt.line_cd = sat_cnt(EXT_W'(sub_sat) + EXT_W'(add));
      end
    end

    // Result fields follow the updated state.
    res.current_line = nxt.line;
    res.lcd_mode     = nxt.mode;
    res.coincidence  = nxt.coin;
    if (nxt.line_cd[lcdt_pkg::CNT_W-1]) begin
      res.cycles_to_event = '0;
    end else if (nxt.line_cd > lcdt_pkg::CNT_W'(lcdt_pkg::CTE_MAX)) begin
      res.cycles_to_event = lcdt_pkg::CTE_MAX;
    end else begin
      res.cycles_to_event = nxt.line_cd[lcdt_pkg::CTE_W-1:0];
    end

    state_o  = nxt;
    result_o = res;
  end

endmodule

// File: hw/rtl/lcd_scanline_mode_timer.sv
// ----------------------------------------------------------------------------
// LCD scan-line mode timer
// Turns elapsed machine cycle counts into display mode, line and interrupt
// events, one result beat for every input beat.
// ----------------------------------------------------------------------------
// Each input beat of elapsed cycles is latched in an input register and then
// processed by one pass of step logic that updates the timer state and loads
// the result register together, once the result register is free; a new beat
// can be taken every clock while the output is not stalled. The input register
// can still take a beat while an unclaimed result sits in the result register;
// input stalls once both are full. Configuration writes are accepted every cycle
// and take effect on the next processed beat; they should only be made while
// no beat is in flight.
module lcd_scanline_mode_timer #(
  parameter int unsigned FRAME_CYCLES = lcdt_pkg::FRAME_CYCLES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  lcdt_pkg::cfg_idx_e                  cfg_index_i,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lcdt_pkg::CYC_W-1:0]          elapsed_cycles_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lcdt_pkg::LINE_W-1:0]         current_line_o,
  output logic [1:0]                          lcd_mode_o,
  output logic                                coincidence_o,
  output logic                                vblank_irq_o,
  output logic                                stat_irq_o,
  output logic                                frame_done_o,
  output logic                                draw_line_o,
  output logic                                hblank_start_o,
  output logic [lcdt_pkg::CTE_W-1:0]          cycles_to_event_o
);

  lcdt_pkg::cfg_t    cfg;
  lcdt_pkg::state_t  state_q, state_d;
  lcdt_pkg::result_t res_q, res_d;
  logic                          s1_valid_q;
  logic [lcdt_pkg::CYC_W-1:0]    s1_cyc_q;
  logic                          out_valid_q;
  logic                          adv;
  logic                          in_take;

  // Configuration registers.
  lcdt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Step logic between the input register and the result register.
  lcdt_step #(
    .FRAME_CYCLES (FRAME_CYCLES)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .cyc_i    (s1_cyc_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // The result register moves when empty or when its beat is taken.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cyc_q <= elapsed_cycles_i;
    end
  end

  // Timer state advances with each processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.line_cd  <= lcdt_pkg::CNT_W'(lcdt_pkg::LINE_CYCLES);
      state_q.frame_cd <= lcdt_pkg::CNT_W'(FRAME_CYCLES - lcdt_pkg::LINE_CYCLES);
      state_q.line     <= '0;
      state_q.mode     <= lcdt_pkg::MODE_HBLANK;
      state_q.coin     <= 1'b0;
    end else if (adv && s1_valid_q) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_line_o    = res_q.current_line;
  assign lcd_mode_o        = res_q.lcd_mode;
  assign coincidence_o     = res_q.coincidence;
  assign vblank_irq_o      = res_q.vblank_irq;
  assign stat_irq_o        = res_q.stat_irq;
  assign frame_done_o      = res_q.frame_done;
  assign draw_line_o       = res_q.draw_line;
  assign hblank_start_o    = res_q.hblank_start;
  assign cycles_to_event_o = res_q.cycles_to_event;

  // An accepted input beat is held in the input register next cycle.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted input beat was lost");

  // Vertical blank begins only on the first blank line and ends a frame.
  a_vblank_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && vblank_irq_o) |->
      (frame_done_o && (current_line_o == lcdt_pkg::LINE_VBLANK_START)))
    else $error("vblank pulse off the first blank line");

  // A draw pulse is always reported with the transfer mode.
  a_draw_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && draw_line_o) |-> (lcd_mode_o == lcdt_pkg::MODE_XFER))
    else $error("draw pulse outside pixel transfer");

  // Blank mode on a visible line only occurs on the wrapped line zero.
  a_vblank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (lcd_mode_o == lcdt_pkg::MODE_VBLANK)) |->
      ((current_line_o >= lcdt_pkg::LINE_VBLANK_START) || (current_line_o == '0)))
    else $error("vertical blank mode on a visible line");

endmodule
